>>> hdl/cflw_pkg.sv
// ----------------------------------------------------------------------------
// cflw_pkg
// Shared types and constants of the chunked flash log writer.
// ----------------------------------------------------------------------------
package cflw_pkg;

	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;
	localparam int READER_W    = 7;
	localparam int PAGE_W      = 4;
	localparam int ADDR_W      = 12;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		OP_STATUS = 2'd0,
		OP_ERASE  = 2'd1,
		OP_WRITE  = 2'd2
	} op_t;

	typedef enum logic {
		REG_STORE_ENABLE = 1'b0,
		REG_START_CHUNK  = 1'b1
	} reg_idx_t;

	// classified transaction handed from front to back
	typedef struct packed {
		logic                is_pop;
		logic                byte_accepted;
		logic                more_pending;
		logic [READER_W-1:0] reader;
		logic [31:0]         battery;
		logic [31:0]         word;
		logic [31:0]         stamp;
	} cmd_t;

	typedef struct packed {
		op_t                 op;
		logic [PAGE_W-1:0]   page;
		logic [ADDR_W-1:0]   word_addr;
		logic [31:0]         data_word;
		logic                byte_accepted;
		logic                more_pending;
		logic [READER_W-1:0] reader_chunk_out;
		logic                last;
	} result_t;

	typedef struct packed {
		logic                load;
		logic [READER_W-1:0] chunk;
	} chunk_cfg_t;

endpackage

>>> hdl/cflw_if.sv
// ----------------------------------------------------------------------------
// cflw_if
// Item and result channels of the chunked flash log writer.
// ----------------------------------------------------------------------------
interface cflw_item_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic [31:0] timestamp;
	logic [31:0] battery_word;
	logic [6:0]  reader_chunk;

	modport source (output valid, kind, data_byte, timestamp, battery_word, reader_chunk,
		input ready);
	modport sink (input valid, kind, data_byte, timestamp, battery_word, reader_chunk,
		output ready);
endinterface

interface cflw_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [3:0]  page;
	logic [11:0] word_addr;
	logic [31:0] data_word;
	logic        byte_accepted;
	logic        more_pending;
	logic [6:0]  reader_chunk_out;
	logic        last;

	modport source (output valid, op, page, word_addr, data_word, byte_accepted,
		more_pending, reader_chunk_out, last, input ready);
	modport sink (input valid, op, page, word_addr, data_word, byte_accepted,
		more_pending, reader_chunk_out, last, output ready);
endinterface

>>> hdl/chunked_flash_log_writer.sv
// ----------------------------------------------------------------------------
// chunked_flash_log_writer
// Byte packer and circular chunked flash log sequencer.
// ----------------------------------------------------------------------------
// Each item transaction yields one result (byte and idle update items) or up
// to four flash commands (update items that move a word), in item order. The
// front takes an item per cycle while its one-entry stage can drain into a
// two-entry queue; the back sequencer emits at most one result per cycle and
// sets the throughput: it takes no new transaction until it is back in idle,
// so an update that moves a word blocks it until its last command is issued.
// The first result passes the front stage, queue and result register;
// an update opening a chunk without an erase loads it from the header state.
// A result held by the sink stalls only the sequencer; the front and queue
// keep taking items until the queue fills.
module chunked_flash_log_writer #(
	parameter int NUM_PAGES   = 16,
	parameter int CHUNK_WORDS = 32,
	parameter int FIFO_WORDS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	cflw_item_if.sink                     items,
	cflw_result_if.source                 results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cflw_pkg::APB_AW-1:0]   paddr,
	input  logic [cflw_pkg::APB_DW-1:0]   pwdata,
	output logic [cflw_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	localparam int LAST_CHUNK = NUM_PAGES * 8 - 1;

	logic                 store_enable_q;
	logic [6:0]           start_chunk_q;
	logic                 cfg_wr, start_ok;
	cflw_pkg::reg_idx_t   reg_idx;
	cflw_pkg::chunk_cfg_t chunk_cfg;
	cflw_pkg::cmd_t       front_cmd, back_cmd;
	logic                 front_valid, front_ready, back_valid, back_ready;
	cflw_pkg::result_t    res;
	logic                 res_valid;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign reg_idx  = cflw_pkg::reg_idx_t'(paddr[2]);
	assign start_ok = int'(pwdata[6:0]) <= LAST_CHUNK;

	assign chunk_cfg.load  = cfg_wr && (reg_idx == cflw_pkg::REG_START_CHUNK) && start_ok;
	assign chunk_cfg.chunk = pwdata[6:0];

	always_comb begin
		unique case (reg_idx)
			cflw_pkg::REG_STORE_ENABLE: prdata = {31'b0, store_enable_q};
			cflw_pkg::REG_START_CHUNK:  prdata = {25'b0, start_chunk_q};
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_enable_q <= 1'b0;
			start_chunk_q  <= '0;
		end else begin
			if (cfg_wr && (reg_idx == cflw_pkg::REG_STORE_ENABLE)) begin
				store_enable_q <= pwdata[0];
			end
			if (chunk_cfg.load) begin
				start_chunk_q <= pwdata[6:0];
			end
		end
	end

	cflw_front #(
		.FIFO_WORDS(FIFO_WORDS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.items        (items),
		.store_enable (store_enable_q),
		.cmd_valid    (front_valid),
		.cmd_ready    (front_ready),
		.cmd          (front_cmd)
	);

	cflw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_cmd    (back_cmd)
	);

	cflw_back #(
		.NUM_PAGES   (NUM_PAGES),
		.CHUNK_WORDS (CHUNK_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (chunk_cfg),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.res_valid (res_valid),
		.res_ready (results.ready),
		.res       (res)
	);

	assign results.valid            = res_valid;
	assign results.op               = res.op;
	assign results.page             = res.page;
	assign results.word_addr        = res.word_addr;
	assign results.data_word        = res.data_word;
	assign results.byte_accepted    = res.byte_accepted;
	assign results.more_pending     = res.more_pending;
	assign results.reader_chunk_out = res.reader_chunk_out;
	assign results.last             = res.last;

endmodule

>>> hdl/cflw_front.sv
// ----------------------------------------------------------------------------
// cflw_front
// Accepts items, packs bytes into the word FIFO, decides pops and reads the
// popped word, and hands one classified transaction per item to the queue.
// ----------------------------------------------------------------------------
module cflw_front #(
	parameter int FIFO_WORDS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	cflw_item_if.sink      items,
	input  logic           store_enable,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output cflw_pkg::cmd_t cmd
);

	localparam int PW = $clog2(FIFO_WORDS);

	logic [PW-1:0] in_pos_q, out_pos_q;
	logic [PW-1:0] in_pos_inc, out_pos_inc, in_pos_d, out_pos_d;
	logic [1:0]    offset_q;
	logic [31:0]   word_q, stamp_q, word_d, stamp_d;
	logic [63:0]   mem_q [FIFO_WORDS];
	logic [63:0]   mem_rd_q;
	logic          accept, full, take_byte, word_done, pop;

	logic          s1_valid_q;
	logic          pop_s1, acc_s1, more_s1;
	logic [6:0]    reader_s1;
	logic [31:0]   batt_s1;

	assign items.ready = !s1_valid_q || cmd_ready;
	assign accept      = items.valid && items.ready;

	assign in_pos_inc  = (in_pos_q == PW'(FIFO_WORDS - 1)) ? '0 : in_pos_q + 1'b1;
	assign out_pos_inc = (out_pos_q == PW'(FIFO_WORDS - 1)) ? '0 : out_pos_q + 1'b1;
	assign full        = in_pos_inc == out_pos_q;
	assign take_byte   = accept && !items.kind && !full;
	assign word_done   = take_byte && (offset_q == 2'd3);
	assign pop         = accept && items.kind && store_enable && (in_pos_q != out_pos_q);
	assign in_pos_d    = word_done ? in_pos_inc : in_pos_q;
	assign out_pos_d   = pop ? out_pos_inc : out_pos_q;
	assign stamp_d     = (offset_q == 2'd0) ? items.timestamp : stamp_q;

	always_comb begin
		word_d = word_q;
		word_d[8*offset_q +: 8] = items.data_byte;
	end

	always_comb begin
		cmd.is_pop        = pop_s1;
		cmd.byte_accepted = acc_s1;
		cmd.more_pending  = more_s1;
		cmd.reader        = reader_s1;
		cmd.battery       = batt_s1;
		cmd.word          = mem_rd_q[31:0];
		cmd.stamp         = mem_rd_q[63:32];
	end

	assign cmd_valid = s1_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pos_q   <= '0;
			out_pos_q  <= '0;
			offset_q   <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (take_byte) begin
				offset_q <= offset_q + 1'b1;
			end
			in_pos_q  <= in_pos_d;
			out_pos_q <= out_pos_d;
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (cmd_ready) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_byte) begin
			word_q  <= word_d;
			stamp_q <= stamp_d;
		end
		if (accept) begin
			pop_s1    <= pop;
			acc_s1    <= take_byte;
			more_s1   <= store_enable && (in_pos_d != out_pos_d);
			reader_s1 <= items.reader_chunk;
			batt_s1   <= items.battery_word;
		end
	end

	always_ff @(posedge clk) begin
		if (word_done) begin
			mem_q[in_pos_q] <= {stamp_d, word_d};
		end
		if (pop) begin
			mem_rd_q <= mem_q[out_pos_q];
		end
	end

endmodule

>>> hdl/cflw_queue.sv
// ----------------------------------------------------------------------------
// cflw_queue
// Short FIFO of classified transactions between front and back.
// ----------------------------------------------------------------------------
module cflw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  cflw_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output cflw_pkg::cmd_t pop_cmd
);

	localparam int QPW = cflw_pkg::QUEUE_PW;

	cflw_pkg::cmd_t slot_q [cflw_pkg::QUEUE_DEPTH];
	logic [QPW-1:0] wr_q, rd_q;
	logic [QPW:0]   count_q;
	logic           push, pop;

	assign push_ready = count_q != (QPW + 1)'(cflw_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPW'(cflw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPW'(cflw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

endmodule

>>> hdl/cflw_back.sv
// ----------------------------------------------------------------------------
// cflw_back
// Sequencer that turns transactions into flash commands: chunk advance, page
// erase with reader push, header words, data word and end-of-chunk mark.
// ----------------------------------------------------------------------------
module cflw_back #(
	parameter int NUM_PAGES   = 16,
	parameter int CHUNK_WORDS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cflw_pkg::chunk_cfg_t cfg,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  cflw_pkg::cmd_t       cmd,
	output logic                 res_valid,
	input  logic                 res_ready,
	output cflw_pkg::result_t    res
);

	localparam int PGB        = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int CHB        = PGB + 3;
	localparam int LOCW       = $clog2(CHUNK_WORDS);
	localparam int LAST_CHUNK = NUM_PAGES * 8 - 1;
	localparam int AW         = (CHB + LOCW > cflw_pkg::ADDR_W) ? CHB + LOCW
	                                                            : cflw_pkg::ADDR_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HTIME,
		ST_HBATT,
		ST_DATA,
		ST_MARK
	} state_t;

	state_t            state_q;
	logic [CHB-1:0]    chunk_q, chunk_nxt, push_ch;
	logic [PGB-1:0]    page_cur, page_nxt;
	logic [LOCW-1:0]   loc_q, loc_inc;
	logic [31:0]       chunk_time_q;
	cflw_pkg::cmd_t    cur_q, cmd_in;
	cflw_pkg::result_t res_q;
	logic              res_valid_q, out_free, page_change, reader_hit, res_load;
	logic [6:0]        reader_new;
	logic [AW-1:0]     addr_full;

	function automatic cflw_pkg::result_t mk(cflw_pkg::op_t op, logic [3:0] page,
		logic [11:0] addr, logic [31:0] data, cflw_pkg::cmd_t c, logic [6:0] reader,
		logic last);
		cflw_pkg::result_t r;
		r.op               = op;
		r.page             = page;
		r.word_addr        = addr;
		r.data_word        = data;
		r.byte_accepted    = c.byte_accepted;
		r.more_pending     = c.more_pending;
		r.reader_chunk_out = reader;
		r.last             = last;
		return r;
	endfunction

	assign out_free    = !res_valid_q || res_ready;
	assign cmd_ready   = (state_q == ST_IDLE) && out_free;
	assign chunk_nxt   = (chunk_q == CHB'(LAST_CHUNK)) ? '0 : chunk_q + 1'b1;
	assign page_cur    = chunk_q[CHB-1:3];
	assign page_nxt    = chunk_nxt[CHB-1:3];
	assign page_change = page_nxt != page_cur;
	assign reader_hit  = 32'(cmd.reader[6:3]) == 32'(page_nxt);
	assign push_ch     = (page_nxt == PGB'(NUM_PAGES - 1)) ? '0 : {page_nxt + 1'b1, 3'b000};
	assign reader_new  = reader_hit ? 7'(push_ch) : cmd.reader;
	assign loc_inc     = loc_q + 1'b1;
	assign addr_full   = AW'(chunk_q) * AW'(CHUNK_WORDS) + AW'(loc_q);
	assign res_valid   = res_valid_q;
	assign res         = res_q;

	always_comb begin
		cmd_in = cmd;
		if (cmd.is_pop && (loc_q == '0) && page_change) begin
			cmd_in.reader = reader_new;
		end
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE: res_load = out_free && cmd_valid
				&& (!cmd.is_pop || ((loc_q == '0) && page_change));
			ST_HTIME, ST_HBATT, ST_DATA, ST_MARK: res_load = out_free;
			default: res_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			chunk_q      <= '0;
			loc_q        <= '0;
			chunk_time_q <= '0;
			cur_q        <= '0;
			res_q        <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg.load) begin
				chunk_q <= CHB'(cfg.chunk);
				loc_q   <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid && out_free) begin
						cur_q <= cmd_in;
						if (!cmd.is_pop) begin
							res_q <= mk(cflw_pkg::OP_STATUS, '0, '0, '0, cmd, cmd.reader,
								1'b1);
						end else if (loc_q == '0) begin
							chunk_q <= chunk_nxt;
							if (page_change) begin
								res_q <= mk(cflw_pkg::OP_ERASE, 4'(page_nxt), '0, '0, cmd,
									reader_new, 1'b0);
							end
							state_q <= ST_HTIME;
						end else begin
							state_q <= ST_DATA;
						end
					end
				end
				ST_HTIME: begin
					if (out_free) begin
						res_q <= mk(cflw_pkg::OP_WRITE, '0, addr_full[11:0], cur_q.stamp,
							cur_q, cur_q.reader, 1'b0);
						chunk_time_q <= cur_q.stamp;
						loc_q        <= loc_inc;
						state_q      <= ST_HBATT;
					end
				end
				ST_HBATT: begin
					if (out_free) begin
						res_q <= mk(cflw_pkg::OP_WRITE, '0, addr_full[11:0], cur_q.battery,
							cur_q, cur_q.reader, 1'b0);
						loc_q   <= loc_inc;
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (out_free) begin
						loc_q <= loc_inc;
						if (loc_inc == LOCW'(CHUNK_WORDS - 1)) begin
							res_q <= mk(cflw_pkg::OP_WRITE, '0, addr_full[11:0], cur_q.word,
								cur_q, cur_q.reader, 1'b0);
							state_q <= ST_MARK;
						end else begin
							res_q <= mk(cflw_pkg::OP_WRITE, '0, addr_full[11:0], cur_q.word,
								cur_q, cur_q.reader, 1'b1);
							state_q <= ST_IDLE;
						end
					end
				end
				ST_MARK: begin
					if (out_free) begin
						res_q <= mk(cflw_pkg::OP_WRITE, '0, addr_full[11:0], chunk_time_q,
							cur_q, cur_q.reader, 1'b1);
						loc_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/cflw_check.sv
// ----------------------------------------------------------------------------
// cflw_check
// Port-level checks on the result channel of the log writer.
// ----------------------------------------------------------------------------
module cflw_check (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  op,
	input logic [3:0]  page,
	input logic [11:0] word_addr,
	input logic [31:0] data_word,
	input logic        byte_accepted,
	input logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(op) && $stable(word_addr)
			&& $stable(data_word) && $stable(last))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && op == cflw_pkg::OP_STATUS |->
			page == '0 && word_addr == '0 && data_word == '0 && last)
		else $error("status result carries flash fields or is not last");

	a_erase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && op == cflw_pkg::OP_ERASE |->
			!last && word_addr == '0 && data_word == '0 && !byte_accepted)
		else $error("erase result malformed");

	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && op == cflw_pkg::OP_WRITE |-> page == '0 && !byte_accepted)
		else $error("write result malformed");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && byte_accepted |-> op == cflw_pkg::OP_STATUS)
		else $error("byte accepted on a flash command");

endmodule

bind chunked_flash_log_writer cflw_check u_cflw_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (results.valid),
	.res_ready     (results.ready),
	.op            (results.op),
	.page          (results.page),
	.word_addr     (results.word_addr),
	.data_word     (results.data_word),
	.byte_accepted (results.byte_accepted),
	.last          (results.last)
);
